@@ src/ttg_pkg.sv @@
// ----------------------------------------------------------------------------
// ttg_pkg
// Field widths, fixed-point constants and sequencer codes for the triangle
// tangent generator.
// ----------------------------------------------------------------------------
package ttg_pkg;

  localparam int POS_W   = 24;   // Q12.12 position
  localparam int UV_W    = 16;   // Q4.12 texture coordinate
  localparam int TAN_W   = 16;   // Q1.14 tangent
  localparam int IDX_W   = 24;   // index field on the ports
  localparam int DP_W    = POS_W + 1;
  localparam int DUV_W   = UV_W + 1;
  localparam int MAG_W   = 43;   // |T| before scaling
  localparam int NRM_W   = 30;   // |T| after scaling, below 2^30
  localparam int OP_W    = 31;   // signed multiplier operand
  localparam int PROD_W  = 2 * OP_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int SUM_W   = 62;   // sum of three squares
  localparam int ROOT_W  = 31;
  localparam int Q_W     = 15;   // quotient magnitude
  localparam int NUM_W   = NRM_W + 15;

  localparam logic [Q_W-1:0] UNIT_Q14 = 15'd16384;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DIVI = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  typedef logic signed [DP_W-1:0]  dp_t;
  typedef logic signed [DUV_W-1:0] duv_t;

endpackage

@@ src/triangle_tangent_generator.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_generator
// Per-triangle unit tangent from corner positions and texture coordinates.
// ----------------------------------------------------------------------------
// Corners arrive one beat each. The first two corners of a triangle are held
// without stalling the input. The third corner starts a sequence on one shared
// 31x31 signed multiplier: products (UV determinant and the three tangent
// components), right shifts of all three components until they are below
// 2^30, squares, integer square root, restoring division for each component,
// then three result beats. The input stays stalled from the third corner
// until the last result beat is registered; a degenerate triangle goes from
// the products straight to the result beats. Result beats come out in corner
// order, the third one flagged last_of_triangle.
module triangle_tangent_generator #(
  parameter int INDEX_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ttg_pkg::IDX_W-1:0]         in_vertex_index,
  input  logic signed [ttg_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [ttg_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [ttg_pkg::POS_W-1:0]  in_pos_z,
  input  logic signed [ttg_pkg::UV_W-1:0]   in_tex_u,
  input  logic signed [ttg_pkg::UV_W-1:0]   in_tex_v,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ttg_pkg::IDX_W-1:0]         out_target_index,
  output logic signed [ttg_pkg::TAN_W-1:0]  out_tangent_x,
  output logic signed [ttg_pkg::TAN_W-1:0]  out_tangent_y,
  output logic signed [ttg_pkg::TAN_W-1:0]  out_tangent_z,
  output logic                              out_degenerate,
  output logic                              out_last_of_triangle
);

  localparam int KEEP_W = (INDEX_BITS < ttg_pkg::IDX_W) ? INDEX_BITS : ttg_pkg::IDX_W;

  logic [2:0]                       state_r;
  logic [1:0]                       phase_r;
  logic [4:0]                       cnt_r;
  logic [1:0]                       comp_r;

  logic signed [ttg_pkg::POS_W-1:0] hpos_r [2][3];
  logic signed [ttg_pkg::UV_W-1:0]  huv_r  [2][2];
  logic [KEEP_W-1:0]                hidx_r [2];
  logic [KEEP_W-1:0]                idx2_r;

  ttg_pkg::dp_t                     dp1_r [3];
  ttg_pkg::dp_t                     dp2_r [3];
  ttg_pkg::duv_t                    du1_r, dv1_r, du2_r, dv2_r;

  logic signed [ttg_pkg::ACC_W-1:0] acc_r;
  logic                             det_zero_r, det_neg_r;
  logic [ttg_pkg::MAG_W-1:0]        mag_r [3];
  logic                             tneg_r [3];
  logic                             degen_r;

  logic [ttg_pkg::SUM_W-1:0]        rem_r;
  logic [ttg_pkg::SUM_W-1:0]        res_r;
  logic [ttg_pkg::SUM_W-1:0]        bit_r;
  logic [ttg_pkg::ROOT_W-1:0]       s_r;

  logic [ttg_pkg::ROOT_W-1:0]       r_r;
  logic [14:0]                      low_r;
  logic [ttg_pkg::Q_W-1:0]          q_r;
  logic signed [ttg_pkg::TAN_W-1:0] tan_r [3];

  logic                             out_valid_r;
  logic [ttg_pkg::IDX_W-1:0]        out_idx_r;
  logic signed [ttg_pkg::TAN_W-1:0] out_tx_r, out_ty_r, out_tz_r;
  logic                             out_degen_r, out_last_r;

  // shared multiplier
  logic signed [ttg_pkg::OP_W-1:0]   op_a, op_b;
  logic signed [ttg_pkg::PROD_W-1:0] prod;
  logic signed [ttg_pkg::ACC_W-1:0]  diff;
  logic [ttg_pkg::ACC_W-1:0]         diff_mag;
  logic [1:0]                        tsel;

  always_comb begin
    op_a = '0;
    op_b = '0;
    tsel = 2'(cnt_r[2:1] - 2'd1);
    if (state_r == ttg_pkg::S_SQ) begin
      op_a = ttg_pkg::OP_W'({1'b0, mag_r[comp_r][ttg_pkg::NRM_W-1:0]});
      op_b = op_a;
    end else begin
      case (cnt_r[2:0])
        3'd0:    begin op_a = ttg_pkg::OP_W'(du1_r); op_b = ttg_pkg::OP_W'(dv2_r); end
        3'd1:    begin op_a = ttg_pkg::OP_W'(dv1_r); op_b = ttg_pkg::OP_W'(du2_r); end
        3'd2:    begin op_a = ttg_pkg::OP_W'(dp1_r[0]); op_b = ttg_pkg::OP_W'(dv2_r); end
        3'd3:    begin op_a = ttg_pkg::OP_W'(dp2_r[0]); op_b = ttg_pkg::OP_W'(dv1_r); end
        3'd4:    begin op_a = ttg_pkg::OP_W'(dp1_r[1]); op_b = ttg_pkg::OP_W'(dv2_r); end
        3'd5:    begin op_a = ttg_pkg::OP_W'(dp2_r[1]); op_b = ttg_pkg::OP_W'(dv1_r); end
        3'd6:    begin op_a = ttg_pkg::OP_W'(dp1_r[2]); op_b = ttg_pkg::OP_W'(dv2_r); end
        default: begin op_a = ttg_pkg::OP_W'(dp2_r[2]); op_b = ttg_pkg::OP_W'(dv1_r); end
      endcase
    end
    prod     = op_a * op_b;
    diff     = acc_r - ttg_pkg::ACC_W'(prod);
    diff_mag = diff[ttg_pkg::ACC_W-1] ? ttg_pkg::ACC_W'(-diff) : ttg_pkg::ACC_W'(diff);
  end

  // square root and division steps
  logic [ttg_pkg::SUM_W-1:0]  trial;
  logic [ttg_pkg::NUM_W-1:0]  num;
  logic [ttg_pkg::ROOT_W:0]   r2;
  logic                       r2_ge;
  logic [ttg_pkg::Q_W-1:0]    q_nxt;
  logic [ttg_pkg::Q_W-1:0]    q_clamp;
  logic [ttg_pkg::ROOT_W-1:0] root;
  logic                       big;
  logic                       accept;

  always_comb begin
    trial   = res_r + bit_r;
    num     = ttg_pkg::NUM_W'({mag_r[comp_r][ttg_pkg::NRM_W-1:0], 14'b0})
              + ttg_pkg::NUM_W'(s_r[ttg_pkg::ROOT_W-1:1]);
    r2      = {r_r, low_r[14]};
    r2_ge   = r2 >= {1'b0, s_r};
    q_nxt   = {q_r[ttg_pkg::Q_W-2:0], r2_ge};
    q_clamp = (q_nxt > ttg_pkg::UNIT_Q14) ? ttg_pkg::UNIT_Q14 : q_nxt;
    root    = (res_r == '0) ? ttg_pkg::ROOT_W'(1) : res_r[ttg_pkg::ROOT_W-1:0];
    big     = (|mag_r[0][ttg_pkg::MAG_W-1:ttg_pkg::NRM_W])
              || (|mag_r[1][ttg_pkg::MAG_W-1:ttg_pkg::NRM_W])
              || (|mag_r[2][ttg_pkg::MAG_W-1:ttg_pkg::NRM_W]);
    accept  = in_valid && !in_stall;
  end

  assign in_stall = (state_r != ttg_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttg_pkg::S_IDLE;
      phase_r     <= 2'd0;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output beat once taken; the output phase reloads it itself
      if (out_valid_r && !out_stall && state_r != ttg_pkg::S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        ttg_pkg::S_IDLE: begin
          if (accept) begin
            case (phase_r)
              2'd1: begin
                hpos_r[1][0] <= in_pos_x;
                hpos_r[1][1] <= in_pos_y;
                hpos_r[1][2] <= in_pos_z;
                huv_r[1][0]  <= in_tex_u;
                huv_r[1][1]  <= in_tex_v;
                hidx_r[1]    <= in_vertex_index[KEEP_W-1:0];
                phase_r      <= 2'd2;
              end
              2'd2: begin
                for (int i = 0; i < 3; i++) begin
                  dp1_r[i] <= ttg_pkg::DP_W'(hpos_r[1][i]) - ttg_pkg::DP_W'(hpos_r[0][i]);
                end
                dp2_r[0] <= ttg_pkg::DP_W'(in_pos_x) - ttg_pkg::DP_W'(hpos_r[0][0]);
                dp2_r[1] <= ttg_pkg::DP_W'(in_pos_y) - ttg_pkg::DP_W'(hpos_r[0][1]);
                dp2_r[2] <= ttg_pkg::DP_W'(in_pos_z) - ttg_pkg::DP_W'(hpos_r[0][2]);
                du1_r    <= ttg_pkg::DUV_W'(huv_r[1][0]) - ttg_pkg::DUV_W'(huv_r[0][0]);
                dv1_r    <= ttg_pkg::DUV_W'(huv_r[1][1]) - ttg_pkg::DUV_W'(huv_r[0][1]);
                du2_r    <= ttg_pkg::DUV_W'(in_tex_u) - ttg_pkg::DUV_W'(huv_r[0][0]);
                dv2_r    <= ttg_pkg::DUV_W'(in_tex_v) - ttg_pkg::DUV_W'(huv_r[0][1]);
                idx2_r   <= in_vertex_index[KEEP_W-1:0];
                phase_r  <= 2'd0;
                cnt_r    <= '0;
                state_r  <= ttg_pkg::S_MUL;
              end
              default: begin
                hpos_r[0][0] <= in_pos_x;
                hpos_r[0][1] <= in_pos_y;
                hpos_r[0][2] <= in_pos_z;
                huv_r[0][0]  <= in_tex_u;
                huv_r[0][1]  <= in_tex_v;
                hidx_r[0]    <= in_vertex_index[KEEP_W-1:0];
                phase_r      <= 2'd1;
              end
            endcase
          end
        end

        ttg_pkg::S_MUL: begin
          if (!cnt_r[0]) begin
            acc_r <= ttg_pkg::ACC_W'(prod);
          end else if (cnt_r[2:1] == 2'd0) begin
            det_zero_r <= (diff == '0);
            det_neg_r  <= diff[ttg_pkg::ACC_W-1];
          end else begin
            mag_r[tsel]  <= diff_mag[ttg_pkg::MAG_W-1:0];
            tneg_r[tsel] <= diff[ttg_pkg::ACC_W-1];
          end
          cnt_r <= 5'(cnt_r + 5'd1);
          if (cnt_r[2:0] == 3'd7) state_r <= ttg_pkg::S_NORM;
        end

        ttg_pkg::S_NORM: begin
          if (det_zero_r || (mag_r[0] == '0 && mag_r[1] == '0 && mag_r[2] == '0)) begin
            degen_r <= 1'b1;
            for (int i = 0; i < 3; i++) tan_r[i] <= '0;
            comp_r  <= '0;
            state_r <= ttg_pkg::S_OUT;
          end else if (big) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else begin
            degen_r <= 1'b0;
            comp_r  <= '0;
            rem_r   <= '0;
            state_r <= ttg_pkg::S_SQ;
          end
        end

        ttg_pkg::S_SQ: begin
          rem_r <= rem_r + ttg_pkg::SUM_W'(prod);
          if (comp_r == 2'd2) begin
            res_r   <= '0;
            bit_r   <= ttg_pkg::SUM_W'(1) << (ttg_pkg::SUM_W - 2);
            cnt_r   <= '0;
            state_r <= ttg_pkg::S_SQRT;
          end else begin
            comp_r <= 2'(comp_r + 2'd1);
          end
        end

        ttg_pkg::S_SQRT: begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= 5'(cnt_r + 5'd1);
          if (cnt_r == 5'd30) begin
            comp_r  <= '0;
            state_r <= ttg_pkg::S_DIVI;
          end
        end

        ttg_pkg::S_DIVI: begin
          // load the root into the divisor first unless the divisor already matches
          if (s_r == root) begin
            r_r     <= ttg_pkg::ROOT_W'(num[ttg_pkg::NUM_W-1:15]);
            low_r   <= num[14:0];
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= ttg_pkg::S_DIV;
          end else begin
            s_r <= root;
          end
        end

        ttg_pkg::S_DIV: begin
          r_r   <= r2_ge ? ttg_pkg::ROOT_W'(r2 - {1'b0, s_r}) : r2[ttg_pkg::ROOT_W-1:0];
          low_r <= {low_r[13:0], 1'b0};
          q_r   <= q_nxt;
          cnt_r <= 5'(cnt_r + 5'd1);
          if (cnt_r == 5'd14) begin
            tan_r[comp_r] <= (tneg_r[comp_r] != det_neg_r)
                             ? ttg_pkg::TAN_W'(-{1'b0, q_clamp})
                             : ttg_pkg::TAN_W'({1'b0, q_clamp});
            if (comp_r == 2'd2) begin
              comp_r  <= '0;
              state_r <= ttg_pkg::S_OUT;
            end else begin
              comp_r  <= 2'(comp_r + 2'd1);
              state_r <= ttg_pkg::S_DIVI;
            end
          end
        end

        ttg_pkg::S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_tx_r    <= tan_r[0];
            out_ty_r    <= tan_r[1];
            out_tz_r    <= tan_r[2];
            out_degen_r <= degen_r;
            out_last_r  <= (comp_r == 2'd2);
            case (comp_r)
              2'd0:    out_idx_r <= ttg_pkg::IDX_W'(hidx_r[0]);
              2'd1:    out_idx_r <= ttg_pkg::IDX_W'(hidx_r[1]);
              default: out_idx_r <= ttg_pkg::IDX_W'(idx2_r);
            endcase
            if (comp_r == 2'd2) state_r <= ttg_pkg::S_IDLE;
            else                comp_r  <= 2'(comp_r + 2'd1);
          end
        end

        default: state_r <= ttg_pkg::S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_target_index     = out_idx_r;
  assign out_tangent_x        = out_tx_r;
  assign out_tangent_y        = out_ty_r;
  assign out_tangent_z        = out_tz_r;
  assign out_degenerate       = out_degen_r;
  assign out_last_of_triangle = out_last_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degen_r |-> out_tx_r == '0 && out_ty_r == '0 && out_tz_r == '0)
    else $error("degenerate beat carries a nonzero tangent");

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ttg_pkg::S_OUT)
    else $error("result beat raised outside the output phase");

  a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == 2'd2 |=> state_r == ttg_pkg::S_MUL)
    else $error("third corner did not start the product sequence");

  a_root_nondegen: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ttg_pkg::S_SQRT |-> !degen_r && !det_zero_r)
    else $error("square root started on a degenerate triangle");

endmodule

@@ test/triangle_tangent_generator_tb.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_generator_tb
// Self-checking bench for the triangle tangent generator: corners are fed
// from a queue with random gaps, the unit tangents of each completed
// triangle are predicted in fixed point and checked against every result
// beat, with random stalls on the result side.
// ----------------------------------------------------------------------------
module triangle_tangent_generator_tb;

  typedef struct {
    logic [ttg_pkg::IDX_W-1:0]        idx;
    logic signed [ttg_pkg::POS_W-1:0] px, py, pz;
    logic signed [ttg_pkg::UV_W-1:0]  u, v;
  } corner_t;

  typedef struct {
    logic [ttg_pkg::IDX_W-1:0]        idx;
    logic signed [ttg_pkg::TAN_W-1:0] tx, ty, tz;
    logic                             degen;
    logic                             last;
  } tangent_t;

  localparam int STALL_LIMIT = 3000;
  localparam longint unsigned MAG_CEIL = 64'd1 << 30;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [ttg_pkg::IDX_W-1:0] in_vertex_index;
  logic signed [ttg_pkg::POS_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [ttg_pkg::UV_W-1:0] in_tex_u, in_tex_v;
  logic out_valid;
  logic out_stall;
  logic [ttg_pkg::IDX_W-1:0] out_target_index;
  logic signed [ttg_pkg::TAN_W-1:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic out_degenerate;
  logic out_last_of_triangle;

  triangle_tangent_generator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vertex_index(in_vertex_index),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_tex_u(in_tex_u), .in_tex_v(in_tex_v),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_target_index(out_target_index),
    .out_tangent_x(out_tangent_x), .out_tangent_y(out_tangent_y),
    .out_tangent_z(out_tangent_z),
    .out_degenerate(out_degenerate),
    .out_last_of_triangle(out_last_of_triangle)
  );

  corner_t  pending_corners[$];
  tangent_t expected_tangents[$];

  // predictor state
  int      held_count;
  corner_t held_corner[2];

  int errors;
  int triangles_seen;
  int degenerate_seen;
  int results_checked;
  int idle_cycles;
  int in_gap;
  int out_wait;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Hold the first two corners; on the third, queue three tangent beats.
  task automatic predict_tangents(input corner_t c);
    longint p0[3], p1[3], p2[3], dp1[3], dp2[3], t[3];
    longint du1, dv1, du2, dv2, det;
    longint unsigned mag[3], mx, sum, s;
    longint unsigned q[3];
    bit neg[3];
    bit degen;
    int k;
    tangent_t r;
    if (held_count < 2) begin
      held_corner[held_count] = c;
      held_count++;
      return;
    end
    held_count = 0;
    p0[0] = held_corner[0].px; p0[1] = held_corner[0].py; p0[2] = held_corner[0].pz;
    p1[0] = held_corner[1].px; p1[1] = held_corner[1].py; p1[2] = held_corner[1].pz;
    p2[0] = c.px; p2[1] = c.py; p2[2] = c.pz;
    du1 = longint'(held_corner[1].u) - longint'(held_corner[0].u);
    dv1 = longint'(held_corner[1].v) - longint'(held_corner[0].v);
    du2 = longint'(c.u) - longint'(held_corner[0].u);
    dv2 = longint'(c.v) - longint'(held_corner[0].v);
    det = du1 * dv2 - dv1 * du2;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      dp1[i] = p1[i] - p0[i];
      dp2[i] = p2[i] - p0[i];
      t[i] = dp1[i] * dv2 - dp2[i] * dv1;
      mag[i] = (t[i] < 0) ? longint'(-t[i]) : longint'(t[i]);
      if (mag[i] > mx) mx = mag[i];
      q[i] = 0;
      neg[i] = 1'b0;
    end
    degen = (det == 0) || (mx == 0);
    if (!degen) begin
      k = 0;
      while ((mx >> k) >= MAG_CEIL) k++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] >>= k;
        sum += mag[i] * mag[i];
      end
      s = isqrt(sum);
      if (s == 0) s = 1;
      for (int i = 0; i < 3; i++) begin
        q[i] = (mag[i] * 16384 + (s >> 1)) / s;
        if (q[i] > 16384) q[i] = 16384;
        neg[i] = (t[i] < 0) != (det < 0);
      end
    end
    triangles_seen++;
    if (degen) degenerate_seen++;
    for (int i = 0; i < 3; i++) begin
      r.idx = (i == 0) ? held_corner[0].idx : (i == 1) ? held_corner[1].idx : c.idx;
      r.tx = neg[0] ? -q[0][15:0] : q[0][15:0];
      r.ty = neg[1] ? -q[1][15:0] : q[1][15:0];
      r.tz = neg[2] ? -q[2][15:0] : q[2][15:0];
      r.degen = degen;
      r.last = (i == 2);
      expected_tangents = {expected_tangents, r};
    end
  endtask

  // driver
  always @(posedge clk) begin
    corner_t c;
    int g;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
      in_vertex_index <= '0;
      in_pos_x <= '0; in_pos_y <= '0; in_pos_z <= '0;
      in_tex_u <= '0; in_tex_v <= '0;
    end else if (in_valid && !in_stall) begin
      c.idx = in_vertex_index;
      c.px = in_pos_x; c.py = in_pos_y; c.pz = in_pos_z;
      c.u = in_tex_u; c.v = in_tex_v;
      predict_tangents(c);
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      g = no_idle ? 0 : $urandom_range(0, 9);
      if (g == 0 && pending_corners.size() > 0) begin
        c = pending_corners.pop_front();
        in_vertex_index <= c.idx;
        in_pos_x <= c.px; in_pos_y <= c.py; in_pos_z <= c.pz;
        in_tex_u <= c.u; in_tex_v <= c.v;
      end else begin
        in_valid <= 1'b0;
        in_gap <= g;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_corners.size() > 0) begin
        c = pending_corners.pop_front();
        in_valid <= 1'b1;
        in_vertex_index <= c.idx;
        in_pos_x <= c.px; in_pos_y <= c.py; in_pos_z <= c.pz;
        in_tex_u <= c.u; in_tex_v <= c.v;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tangent_t e;
    int w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_tangents.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual idx=%h", $time,
                   out_target_index);
        end else begin
          e = expected_tangents.pop_front();
          if (out_target_index !== e.idx || out_tangent_x !== e.tx ||
              out_tangent_y !== e.ty || out_tangent_z !== e.tz ||
              out_degenerate !== e.degen || out_last_of_triangle !== e.last) begin
            errors++;
            $display("%0t: mismatch expected idx=%h t=(%0d,%0d,%0d) dg=%b last=%b",
                     $time, e.idx, e.tx, e.ty, e.tz, e.degen, e.last);
            $display("%0t:          actual   idx=%h t=(%0d,%0d,%0d) dg=%b last=%b",
                     $time, out_target_index, out_tangent_x, out_tangent_y,
                     out_tangent_z, out_degenerate, out_last_of_triangle);
          end
        end
        w = no_idle ? 0 : $urandom_range(0, 9);
        if (w > 0) begin
          out_stall <= 1'b1;
          out_wait <= w;
        end
      end else if (out_stall) begin
        if (out_wait <= 1) out_stall <= 1'b0;
        out_wait <= out_wait - 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("triangle_tangent_generator test failed");
        $finish;
      end
    end
  end

  function automatic corner_t rand_corner(bit narrow);
    corner_t c;
    c.idx = ttg_pkg::IDX_W'($urandom);
    if (narrow) begin
      c.px = ttg_pkg::POS_W'($signed($urandom_range(0, 32767)) - 16384);
      c.py = ttg_pkg::POS_W'($signed($urandom_range(0, 32767)) - 16384);
      c.pz = ttg_pkg::POS_W'($signed($urandom_range(0, 32767)) - 16384);
      c.u = ttg_pkg::UV_W'($signed($urandom_range(0, 8191)) - 4096);
      c.v = ttg_pkg::UV_W'($signed($urandom_range(0, 8191)) - 4096);
    end else begin
      c.px = ttg_pkg::POS_W'($urandom);
      c.py = ttg_pkg::POS_W'($urandom);
      c.pz = ttg_pkg::POS_W'($urandom);
      c.u = ttg_pkg::UV_W'($urandom);
      c.v = ttg_pkg::UV_W'($urandom);
    end
    return c;
  endfunction

  task automatic add_corner(input logic [ttg_pkg::IDX_W-1:0] idx, input int px,
                            input int py, input int pz, input int u, input int v);
    corner_t c;
    c.idx = idx;
    c.px = ttg_pkg::POS_W'(px);
    c.py = ttg_pkg::POS_W'(py);
    c.pz = ttg_pkg::POS_W'(pz);
    c.u = ttg_pkg::UV_W'(u);
    c.v = ttg_pkg::UV_W'(v);
    pending_corners = {pending_corners, c};
  endtask

  initial begin
    corner_t c0, c1, c2;
    int kind;
    int cyc;
    rst_n = 1'b0;

    // plain right triangle along x with unit UV steps
    add_corner(24'd0, 0, 0, 0, 0, 0);
    add_corner(24'd1, 4096, 0, 0, 4096, 0);
    add_corner(24'hFFFFFF, 0, 4096, 0, 0, 4096);
    // extremes of position and UV
    add_corner(24'h800000, -8388608, 8388607, -8388608, -32768, 32767);
    add_corner(24'h7FFFFF, 8388607, -8388608, 8388607, 32767, -32768);
    add_corner(24'h123456, -8388608, -8388608, 8388607, 32767, 32767);
    // zero determinant: all UVs equal
    add_corner(24'd10, 100, 200, 300, 1234, 1234);
    add_corner(24'd11, 5000, -200, 30, 1234, 1234);
    add_corner(24'd12, -700, 900, 3000, 1234, 1234);
    // zero tangent vector: all positions equal, UVs spread
    add_corner(24'd20, 777, -777, 777, 0, 0);
    add_corner(24'd21, 777, -777, 777, 4096, 0);
    add_corner(24'd22, 777, -777, 777, 0, 4096);
    // negative determinant flips the sign
    add_corner(24'd30, 0, 0, 0, 0, 0);
    add_corner(24'd31, 4096, 4096, 0, 0, 4096);
    add_corner(24'd32, 0, 4096, 4096, 4096, 0);

    repeat (77) begin
      kind = $urandom_range(0, 19);
      c0 = rand_corner(kind[0]);
      c1 = rand_corner(kind[0]);
      c2 = rand_corner(1'($urandom_range(0, 1)));
      if (kind == 2) begin
        c1.u = c0.u; c1.v = c0.v; c2.u = c0.u; c2.v = c0.v;
      end else if (kind == 3) begin
        c1.px = c0.px; c1.py = c0.py; c1.pz = c0.pz;
        c2.px = c0.px; c2.py = c0.py; c2.pz = c0.pz;
      end
      pending_corners = {pending_corners, c0, c1, c2};
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_corners.size() == 0 && !in_valid && expected_tangents.size() == 0);
    cyc = 0;
    while (cyc < 200) begin
      @(posedge clk);
      cyc++;
    end
    $display("Covered %0d triangles (%0d degenerate), %0d tangent beats checked.",
             triangles_seen, degenerate_seen, results_checked);
    if (errors == 0 && expected_tangents.size() == 0) begin
      $display("triangle_tangent_generator test passed");
    end else begin
      $display("triangle_tangent_generator test failed");
    end
    $finish;
  end

endmodule

@@ triangle_tangent_generator.f @@
src/ttg_pkg.sv
src/triangle_tangent_generator.sv
test/triangle_tangent_generator_tb.sv
